// ===== rtl/core/setq_pkg.sv =====
// Shared types and sizes for the sorted expiry timer queue.
`timescale 1ns / 1ps
`default_nettype none
package setq_pkg;

  localparam int CAPACITY    = 16;
  localparam int ID_BITS     = 8;
  localparam int TIME_BITS   = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int ID_IN   = (ID_BITS < 8) ? ID_BITS : 8;
  localparam int TIME_IN = (TIME_BITS < 32) ? TIME_BITS : 32;
  localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_ADJUST = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_MISSING = 3'd2,
    ST_EXPIRED = 3'd3,
    ST_NONE    = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  timer_id;
    logic [31:0] expire_time;
    logic [31:0] now_time;
  } request_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] expired_id;
    logic [4:0] count;
    logic       last;
  } result_t;

  typedef struct packed {
    op_t                  op;
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] tval;
  } work_t;

endpackage
`default_nettype wire

// ===== rtl/core/setq_front.sv =====
// Request intake: decodes and masks each request and hands it to the queue.
`timescale 1ns / 1ps
`default_nettype none
module setq_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire setq_pkg::request_t request,
  output logic                   push,
  output setq_pkg::work_t        push_data,
  input  wire logic              q_full
);

  logic            hold_valid;
  setq_pkg::work_t hold;
  setq_pkg::work_t decoded;
  logic            accept;

  always_comb begin
    decoded.op = setq_pkg::op_t'(request.op);
    decoded.id = setq_pkg::ID_BITS'(request.timer_id[setq_pkg::ID_IN-1:0]);
    if (decoded.op == setq_pkg::OP_TICK) begin
      decoded.tval = setq_pkg::TIME_BITS'(request.now_time[setq_pkg::TIME_IN-1:0]);
    end else begin
      decoded.tval = setq_pkg::TIME_BITS'(request.expire_time[setq_pkg::TIME_IN-1:0]);
    end
  end

  assign busy      = hold_valid && q_full;
  assign accept    = start && !busy;
  assign push      = hold_valid && !q_full;
  assign push_data = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= decoded;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/setq_queue.sv =====
// Short request queue between intake and the table sequencer.
`timescale 1ns / 1ps
`default_nettype none
module setq_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire setq_pkg::work_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output logic                 head_valid,
  output setq_pkg::work_t      head
);

  setq_pkg::work_t                  slots [setq_pkg::QUEUE_DEPTH];
  logic [setq_pkg::QPTR_W-1:0]      wr_ptr;
  logic [setq_pkg::QPTR_W-1:0]      rd_ptr;
  logic [setq_pkg::QCNT_W-1:0]      fill;

  assign full       = (fill == setq_pkg::QCNT_W'(setq_pkg::QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == setq_pkg::QPTR_W'(setq_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == setq_pkg::QPTR_W'(setq_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/setq_back.sv =====
// Table sequencer: sorted timer memory walked one entry per cycle.
`timescale 1ns / 1ps
`default_nettype none
module setq_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            head_valid,
  input  wire setq_pkg::work_t head,
  output logic                 pop,
  output logic                 result_strobe,
  output setq_pkg::result_t    result
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_DISP    = 10'b00_0000_0010,
    S_INS     = 10'b00_0000_0100,
    S_INS_CMP = 10'b00_0000_1000,
    S_FND_CMP = 10'b00_0001_0000,
    S_SHD_CMP = 10'b00_0010_0000,
    S_SCAN    = 10'b00_0100_0000,
    S_OUT     = 10'b00_1000_0000,
    S_MOVE    = 10'b01_0000_0000,
    S_REPORT  = 10'b10_0000_0000
  } state_t;

  localparam int SW = setq_pkg::SUM_W;
  localparam int CW = setq_pkg::CNT_W;
  localparam int IW = setq_pkg::IDX_W;

  logic [setq_pkg::TIME_BITS-1:0] exp_mem [setq_pkg::CAPACITY];
  logic [setq_pkg::ID_BITS-1:0]   id_mem  [setq_pkg::CAPACITY];
  logic [setq_pkg::TIME_BITS-1:0] rd_exp;
  logic [setq_pkg::ID_BITS-1:0]   rd_id;

  state_t            state, state_next;
  setq_pkg::work_t   cmd, cmd_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [CW-1:0]     ptr, ptr_next;
  logic [CW-1:0]     npop, npop_next;
  setq_pkg::status_t stat, stat_next;

  logic          we;
  logic [IW-1:0] waddr;
  logic          w_from_rd;
  logic          re;
  logic [SW-1:0] rsum;

  logic [SW-1:0] cnt_w;
  logic [SW-1:0] ptr_w;
  logic [SW-1:0] npop_w;
  logic          ptr1_lt_cnt;
  logic          ptr2_lt_cnt;

  assign cnt_w       = SW'(cnt);
  assign ptr_w       = SW'(ptr);
  assign npop_w      = SW'(npop);
  assign ptr1_lt_cnt = (ptr_w + SW'(1)) < cnt_w;
  assign ptr2_lt_cnt = (ptr_w + SW'(2)) < cnt_w;

  always_comb begin
    state_next    = state;
    cmd_next      = cmd;
    cnt_next      = cnt;
    ptr_next      = ptr;
    npop_next     = npop;
    stat_next     = stat;
    pop           = 1'b0;
    we            = 1'b0;
    waddr         = ptr[IW-1:0];
    w_from_rd     = 1'b0;
    re            = 1'b0;
    rsum          = '0;
    result_strobe = 1'b0;
    result        = '0;
    case (state)
      S_IDLE: begin
        if (head_valid) begin
          pop        = 1'b1;
          cmd_next   = head;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (cmd.op)
          setq_pkg::OP_INSERT: begin
            if (cnt_w >= SW'(setq_pkg::CAPACITY)) begin
              stat_next  = setq_pkg::ST_FULL;
              state_next = S_REPORT;
            end else begin
              ptr_next   = cnt;
              state_next = S_INS;
            end
          end
          setq_pkg::OP_REMOVE, setq_pkg::OP_ADJUST: begin
            if (cnt == '0) begin
              stat_next  = setq_pkg::ST_MISSING;
              state_next = S_REPORT;
            end else begin
              re         = 1'b1;
              ptr_next   = '0;
              state_next = S_FND_CMP;
            end
          end
          default: begin
            if (cnt == '0) begin
              stat_next  = setq_pkg::ST_NONE;
              state_next = S_REPORT;
            end else begin
              re         = 1'b1;
              ptr_next   = '0;
              state_next = S_SCAN;
            end
          end
        endcase
      end
      S_INS: begin
        if (ptr == '0) begin
          we         = 1'b1;
          cnt_next   = cnt + 1'b1;
          stat_next  = setq_pkg::ST_OK;
          state_next = S_REPORT;
        end else begin
          re         = 1'b1;
          rsum       = ptr_w - SW'(1);
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        we = 1'b1;
        if (rd_exp > cmd.tval) begin
          w_from_rd = 1'b1;
          ptr_next  = ptr - 1'b1;
          if (ptr == CW'(1)) begin
            state_next = S_INS;
          end else begin
            re   = 1'b1;
            rsum = ptr_w - SW'(2);
          end
        end else begin
          cnt_next   = cnt + 1'b1;
          stat_next  = setq_pkg::ST_OK;
          state_next = S_REPORT;
        end
      end
      S_FND_CMP: begin
        if (rd_id == cmd.id) begin
          if (ptr1_lt_cnt) begin
            re         = 1'b1;
            rsum       = ptr_w + SW'(1);
            state_next = S_SHD_CMP;
          end else begin
            cnt_next = cnt - 1'b1;
            if (cmd.op == setq_pkg::OP_ADJUST) begin
              ptr_next   = cnt - 1'b1;
              state_next = S_INS;
            end else begin
              stat_next  = setq_pkg::ST_OK;
              state_next = S_REPORT;
            end
          end
        end else if (ptr1_lt_cnt) begin
          re       = 1'b1;
          rsum     = ptr_w + SW'(1);
          ptr_next = ptr + 1'b1;
        end else begin
          stat_next  = setq_pkg::ST_MISSING;
          state_next = S_REPORT;
        end
      end
      S_SHD_CMP: begin
        we        = 1'b1;
        w_from_rd = 1'b1;
        if (ptr2_lt_cnt) begin
          re       = 1'b1;
          rsum     = ptr_w + SW'(2);
          ptr_next = ptr + 1'b1;
        end else begin
          cnt_next = cnt - 1'b1;
          if (cmd.op == setq_pkg::OP_ADJUST) begin
            ptr_next   = cnt - 1'b1;
            state_next = S_INS;
          end else begin
            stat_next  = setq_pkg::ST_OK;
            state_next = S_REPORT;
          end
        end
      end
      S_SCAN: begin
        if (rd_exp <= cmd.tval) begin
          if (ptr1_lt_cnt) begin
            re       = 1'b1;
            rsum     = ptr_w + SW'(1);
            ptr_next = ptr + 1'b1;
          end else begin
            npop_next  = ptr + 1'b1;
            re         = 1'b1;
            ptr_next   = '0;
            state_next = S_OUT;
          end
        end else if (ptr == '0) begin
          stat_next  = setq_pkg::ST_NONE;
          state_next = S_REPORT;
        end else begin
          npop_next  = ptr;
          re         = 1'b1;
          ptr_next   = '0;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        result_strobe     = 1'b1;
        result.status     = setq_pkg::ST_EXPIRED;
        result.expired_id = 8'(rd_id);
        result.count      = 5'(cnt - npop);
        result.last       = ((ptr_w + SW'(1)) == npop_w);
        if ((ptr_w + SW'(1)) < npop_w) begin
          re       = 1'b1;
          rsum     = ptr_w + SW'(1);
          ptr_next = ptr + 1'b1;
        end else if (npop < cnt) begin
          re         = 1'b1;
          rsum       = npop_w;
          ptr_next   = '0;
          state_next = S_MOVE;
        end else begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end
      end
      S_MOVE: begin
        we        = 1'b1;
        w_from_rd = 1'b1;
        if ((ptr_w + npop_w + SW'(1)) < cnt_w) begin
          re       = 1'b1;
          rsum     = ptr_w + npop_w + SW'(1);
          ptr_next = ptr + 1'b1;
        end else begin
          cnt_next   = cnt - npop;
          state_next = S_IDLE;
        end
      end
      S_REPORT: begin
        result_strobe     = 1'b1;
        result.status     = stat;
        result.expired_id = '0;
        result.count      = 5'(cnt);
        result.last       = 1'b1;
        state_next        = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd  <= cmd_next;
    ptr  <= ptr_next;
    npop <= npop_next;
    stat <= stat_next;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      exp_mem[waddr] <= w_from_rd ? rd_exp : cmd.tval;
      id_mem[waddr]  <= w_from_rd ? rd_id : cmd.id;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_exp <= exp_mem[rsum[IW-1:0]];
      rd_id  <= id_mem[rsum[IW-1:0]];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sorted_expiry_timer_queue_core.sv =====
// Top level of the sorted expiry timer queue.
// A request is taken when start is high and busy is low; up to three requests can be taken
// ahead of the one being worked on. Each result appears for exactly one cycle with
// result_strobe high and cannot be held off; a tick that pops timers gives one result per
// popped timer, back to back, with last set on the final one. The table lives in a memory
// with one read and one write port and is walked one entry per cycle. A request passes through
// the intake register and the queue to the sequencer, which searches and shifts the table for
// insert, remove and adjust, and for a tick scans the due entries, reports them, then closes
// the gap.
`timescale 1ns / 1ps
`default_nettype none
module sorted_expiry_timer_queue_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire setq_pkg::request_t request,
  output logic                    result_strobe,
  output setq_pkg::result_t       result
);

  logic            push;
  setq_pkg::work_t push_data;
  logic            q_full;
  logic            pop;
  logic            head_valid;
  setq_pkg::work_t head;

  setq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  setq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  setq_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the sorted expiry timer queue: request driver, result monitor, predictor.
`timescale 1ns / 1ps
module testbench;
  import setq_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 4 * CAPACITY + 40;
  localparam int RANDOM_ITEMS   = 450;

  typedef struct packed {
    logic [TIME_BITS-1:0] expiry;
    logic [ID_BITS-1:0]   id;
  } timer_entry_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     result_strobe;
  result_t  result;

  timer_entry_t timer_list[$];
  result_t      expected_q[$];
  request_t     pending_q[$];

  int n_issued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_expired = 0;
  int n_full = 0;
  int n_missing = 0;
  int widest_burst = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  sorted_expiry_timer_queue_core dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .request       (request),
    .result_strobe (result_strobe),
    .result        (result)
  );

  always #5 clk = ~clk;

  task automatic push_expected(status_t st, logic [7:0] id, logic last);
    result_t r;
    r.status     = st;
    r.expired_id = id;
    r.count      = 5'(timer_list.size());
    r.last       = last;
    expected_q.push_back(r);
  endtask

  task automatic place_timer(logic [7:0] id, logic [31:0] expiry);
    int pos;
    timer_entry_t e;
    pos = timer_list.size();
    while (pos > 0 && timer_list[pos-1].expiry > expiry) pos--;
    e.expiry = expiry;
    e.id     = id;
    timer_list.insert(pos, e);
  endtask

  task automatic predict_request(request_t req);
    int pos;
    logic [7:0] popped[$];
    pos = -1;
    case (op_t'(req.op))
      OP_INSERT: begin
        if (timer_list.size() >= CAPACITY) begin
          push_expected(ST_FULL, '0, 1'b1);
        end else begin
          place_timer(req.timer_id, req.expire_time);
          push_expected(ST_OK, '0, 1'b1);
        end
      end
      OP_REMOVE, OP_ADJUST: begin
        for (int i = 0; i < timer_list.size(); i++) begin
          if (pos < 0 && timer_list[i].id == req.timer_id) pos = i;
        end
        if (pos < 0) begin
          push_expected(ST_MISSING, '0, 1'b1);
        end else begin
          timer_list.delete(pos);
          if (op_t'(req.op) == OP_ADJUST) place_timer(req.timer_id, req.expire_time);
          push_expected(ST_OK, '0, 1'b1);
        end
      end
      OP_TICK: begin
        while (timer_list.size() > 0 && popped.size() < CAPACITY &&
               timer_list[0].expiry <= req.now_time) begin
          popped.push_back(timer_list[0].id);
          timer_list.delete(0);
        end
        if (popped.size() == 0) begin
          push_expected(ST_NONE, '0, 1'b1);
        end else begin
          for (int k = 0; k < popped.size(); k++) begin
            push_expected(ST_EXPIRED, popped[k], k == popped.size() - 1);
          end
        end
      end
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    logic    progress;
    if (!rst) begin
      progress = 1'b0;
      if (result_strobe) begin
        progress = 1'b1;
        n_results++;
        if (result.status == ST_EXPIRED) n_expired++;
        if (result.status == ST_FULL) n_full++;
        if (result.status == ST_MISSING) n_missing++;
        if (expected_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: expected no result, got status %0d id %0d count %0d last %0d",
                   $time, result.status, result.expired_id, result.count, result.last);
        end else begin
          want = expected_q.pop_front();
          check_field("status", 32'(want.status), 32'(result.status));
          check_field("expired_id", 32'(want.expired_id), 32'(result.expired_id));
          check_field("count", 32'(want.count), 32'(result.count));
          check_field("last", 32'(want.last), 32'(result.last));
        end
      end
      if (start && !busy) begin
        progress = 1'b1;
        n_accepted++;
        predict_request(request);
        if (expected_q.size() > widest_burst) widest_burst = expected_q.size();
      end
      quiet_cycles <= progress ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout after %0d quiet cycles", quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    int idle_pct;
    idle_pct = (n_issued < 160) ? 13 : (n_issued < 320) ? 81 : 0;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || n_accepted == n_issued) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        request <= pending_q.pop_front();
        start <= 1'b1;
        n_issued++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic add_request(op_t op, logic [7:0] id, logic [31:0] expiry, logic [31:0] now);
    request_t r;
    r.op          = op;
    r.timer_id    = id;
    r.expire_time = expiry;
    r.now_time    = now;
    pending_q.push_back(r);
  endtask

  initial begin
    logic [31:0] gen_now;
    logic [31:0] expiry;
    logic [31:0] now;
    logic [7:0]  id;
    int mode;
    int pick;
    op_t op;

    add_request(OP_TICK, 8'd3, $urandom, 32'hFFFF_FFFF);
    add_request(OP_REMOVE, 8'd5, $urandom, $urandom);
    add_request(OP_ADJUST, 8'd5, $urandom, $urandom);
    add_request(OP_INSERT, 8'd0, 32'd0, $urandom);
    add_request(OP_INSERT, 8'd255, 32'hFFFF_FFFF, $urandom);
    add_request(OP_INSERT, 8'd7, 32'd100, $urandom);
    add_request(OP_INSERT, 8'd8, 32'd100, $urandom);
    add_request(OP_INSERT, 8'd7, 32'd50, $urandom);
    add_request(OP_REMOVE, 8'd7, $urandom, $urandom);
    add_request(OP_ADJUST, 8'd8, 32'd10, $urandom);
    add_request(OP_TICK, 8'd0, $urandom, 32'd100);
    for (int i = 0; i < CAPACITY; i++) begin
      add_request(OP_INSERT, 8'(16 + i), $urandom, $urandom);
    end
    add_request(OP_TICK, 8'd0, $urandom, 32'hFFFF_FFFF);

    gen_now = 32'd1000;
    mode = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 25 == 0) mode = $urandom_range(2);
      pick = $urandom_range(99);
      case (mode)
        0: op = (pick < 60) ? OP_INSERT : (pick < 70) ? OP_REMOVE :
                (pick < 85) ? OP_ADJUST : OP_TICK;
        1: op = (pick < 35) ? OP_INSERT : (pick < 55) ? OP_REMOVE :
                (pick < 75) ? OP_ADJUST : OP_TICK;
        default: op = (pick < 15) ? OP_INSERT : (pick < 35) ? OP_REMOVE :
                      (pick < 50) ? OP_ADJUST : OP_TICK;
      endcase
      id = ($urandom_range(99) < 85) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
      pick = $urandom_range(99);
      expiry = (pick < 90) ? gen_now + $urandom_range(300) :
               (pick < 97) ? $urandom :
               (pick < 99) ? 32'hFFFF_FFFF : 32'd0;
      now = $urandom;
      if (op == OP_TICK) begin
        gen_now = gen_now + $urandom_range(40);
        pick = $urandom_range(99);
        now = (pick < 94) ? gen_now : (pick < 98) ? $urandom : 32'hFFFF_FFFF;
      end
      add_request(op, id, expiry, now);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || n_accepted != n_issued) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d requests and %0d results: %0d expiry reports, %0d full, %0d missing",
             n_accepted, n_results, n_expired, n_full, n_missing);
    $display("Largest backlog of expected results: %0d", widest_burst);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
